>>> rtl/hsv2rgb_pkg.sv
// Shared widths, divider constants and sector codes for the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int HUE_W  = 9;
  localparam int CH_W   = 8;
  localparam int DIST_W = 6;   // d = 60 - |(hue mod 120) - 60|, 0..60
  localparam int PROD_W = 16;  // 8 x 8 products
  localparam int NUM_W  = 22;  // secondary-term numerator, below 3.91e6

  // Divide by 255: estimate by reciprocal, then one correction step
  localparam int RECIP_N_W  = 17;
  localparam int RECIP_N_SH = 24;
  localparam logic [CH_W-1:0]      DIV_N   = 8'd255;
  localparam logic [RECIP_N_W-1:0] RECIP_N = 17'd65793;   // floor(2^24 / 255)

  // Divide by 15300 (60 * 255): same scheme
  localparam int DIV_X_W    = 14;
  localparam int RECIP_X_W  = 19;
  localparam int RECIP_X_SH = 32;
  localparam logic [DIV_X_W-1:0]   DIV_X   = 14'd15300;
  localparam logic [RECIP_X_W-1:0] RECIP_X = 19'd280716;  // floor(2^32 / 15300)

  // Hue boundaries
  localparam logic [HUE_W-1:0] HUE_60  = 9'd60;
  localparam logic [HUE_W-1:0] HUE_120 = 9'd120;
  localparam logic [HUE_W-1:0] HUE_180 = 9'd180;
  localparam logic [HUE_W-1:0] HUE_240 = 9'd240;
  localparam logic [HUE_W-1:0] HUE_300 = 9'd300;
  localparam logic [HUE_W-1:0] HUE_360 = 9'd360;
  localparam logic [HUE_W-1:0] HUE_480 = 9'd480;

  // 60-degree sectors; hues of 300 and above land in SEC_5
  typedef enum logic [2:0] {
    SEC_0,  // R=C G=X B=0
    SEC_1,  // R=X G=C B=0
    SEC_2,  // R=0 G=C B=X
    SEC_3,  // R=0 G=X B=C
    SEC_4,  // R=X G=0 B=C
    SEC_5   // R=C G=0 B=X
  } sector_t;

endpackage

>>> rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter: five-stage pipeline with exact constant division.
// Each item passes through stages A, B, C and D and then the output registers.
// Throughput: one item per cycle while out_stall is low; each stage holds its item only while the
// stage after it is full and blocked, so a stall loses and repeats nothing.
// Reset (rst, synchronous, active high) clears all stage valid bits; data
// registers are not reset.
module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [HUE_W-1:0] hue,
  input  logic [CH_W-1:0]  saturation,
  input  logic [CH_W-1:0]  brightness,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CH_W-1:0]  red,
  output logic [CH_W-1:0]  green,
  output logic [CH_W-1:0]  blue
);

  // Stage A: sector, hue distance term, saturation and brightness
  logic                a_vld;
  sector_t             a_sec;
  logic [DIST_W-1:0]   a_d;
  logic [CH_W-1:0]     a_s;
  logic [CH_W-1:0]     a_v;
  // Stage B: 8x8 products
  logic                b_vld;
  sector_t             b_sec;
  logic [DIST_W-1:0]   b_d;
  logic [PROD_W-1:0]   b_sv;
  logic [PROD_W-1:0]   b_vinv;
  logic [CH_W-1:0]     b_v;
  // Stage C: numerator, estimate for the zero-chroma channel
  logic                c_vld;
  sector_t             c_sec;
  logic [NUM_W-1:0]    c_num;
  logic [PROD_W-1:0]   c_vinv;
  logic [CH_W-1:0]     c_nq0;
  logic [CH_W-1:0]     c_v;
  // Stage D: estimate for the secondary channel, corrected zero-chroma channel
  logic                d_vld;
  sector_t             d_sec;
  logic [NUM_W-1:0]    d_num;
  logic [CH_W-1:0]     d_xq0;
  logic [CH_W-1:0]     d_none;
  logic [CH_W-1:0]     d_v;

  logic a_rdy, b_rdy, c_rdy, d_rdy, e_rdy;

  // Per-stage ready chain: a stage moves when empty or when the next moves
  assign e_rdy    = !out_valid || !out_stall;
  assign d_rdy    = !d_vld || e_rdy;
  assign c_rdy    = !c_vld || d_rdy;
  assign b_rdy    = !b_vld || c_rdy;
  assign a_rdy    = !a_vld || b_rdy;
  assign in_stall = !a_rdy;

  // Hue mod 120 by parallel compares, then distance and sector
  logic [HUE_W-1:0]  hue_mod;
  logic [HUE_W-1:0]  hue_dist;
  logic [DIST_W-1:0] d_in;
  sector_t           sec_in;

  always_comb begin
    if (hue >= HUE_480) begin
      hue_mod = hue - HUE_480;
    end else if (hue >= HUE_360) begin
      hue_mod = hue - HUE_360;
    end else if (hue >= HUE_240) begin
      hue_mod = hue - HUE_240;
    end else if (hue >= HUE_120) begin
      hue_mod = hue - HUE_120;
    end else begin
      hue_mod = hue;
    end
    hue_dist = (hue_mod >= HUE_60) ? (hue_mod - HUE_60) : (HUE_60 - hue_mod);
    d_in     = DIST_W'(HUE_60 - hue_dist);
    if (hue < HUE_60) begin
      sec_in = SEC_0;
    end else if (hue < HUE_120) begin
      sec_in = SEC_1;
    end else if (hue < HUE_180) begin
      sec_in = SEC_2;
    end else if (hue < HUE_240) begin
      sec_in = SEC_3;
    end else if (hue < HUE_300) begin
      sec_in = SEC_4;
    end else begin
      sec_in = SEC_5;
    end
  end

  // Divide-by-255 correction for the zero-chroma channel
  logic [PROD_W-1:0] n_rem;
  logic [CH_W-1:0]   n_q;
  // Divide-by-15300 estimate for the secondary channel, divide-by-255 estimate for the zero-chroma channel
  logic [NUM_W+RECIP_X_W-1:0] x_prod;
  logic [PROD_W+RECIP_N_W-1:0] n_prod;

  assign n_prod = (PROD_W+RECIP_N_W)'(b_vinv) * (PROD_W+RECIP_N_W)'(RECIP_N);
  assign n_rem  = c_vinv - PROD_W'(c_nq0) * PROD_W'(DIV_N);
  assign n_q    = (n_rem >= PROD_W'(DIV_N)) ? (c_nq0 + 8'd1) : c_nq0;
  assign x_prod = (NUM_W+RECIP_X_W)'(c_num) * (NUM_W+RECIP_X_W)'(RECIP_X);

  // Divide-by-15300 correction in the output stage
  logic [NUM_W-1:0] x_rem;
  logic [CH_W-1:0]  x_q;

  assign x_rem = d_num - NUM_W'(d_xq0) * NUM_W'(DIV_X);
  assign x_q   = (x_rem >= NUM_W'(DIV_X)) ? (d_xq0 + 8'd1) : d_xq0;

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      d_vld     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld <= in_valid;
      end
      if (b_rdy) begin
        b_vld <= a_vld;
      end
      if (c_rdy) begin
        c_vld <= b_vld;
      end
      if (d_rdy) begin
        d_vld <= c_vld;
      end
      if (e_rdy) begin
        out_valid <= d_vld;
      end
    end

    if (a_rdy) begin
      a_sec <= sec_in;
      a_d   <= d_in;
      a_s   <= saturation;
      a_v   <= brightness;
    end
    if (b_rdy) begin
      b_sec  <= a_sec;
      b_d    <= a_d;
      b_v    <= a_v;
      b_sv   <= PROD_W'(a_s) * PROD_W'(a_v);
      b_vinv <= PROD_W'(a_v) * PROD_W'(DIV_N - a_s);
    end
    if (c_rdy) begin
      c_sec  <= b_sec;
      c_v    <= b_v;
      c_vinv <= b_vinv;
      c_num  <= NUM_W'(b_sv) * NUM_W'(b_d) + NUM_W'(b_vinv) * NUM_W'(HUE_60);
      c_nq0  <= n_prod[RECIP_N_SH +: CH_W];
    end
    if (d_rdy) begin
      d_sec  <= c_sec;
      d_v    <= c_v;
      d_num  <= c_num;
      d_none <= n_q;
      d_xq0  <= x_prod[RECIP_X_SH +: CH_W];
    end
    // Output stage: place C, X and the offset-only value by sector
    if (e_rdy) begin
      case (d_sec)
        SEC_0: begin
          red <= d_v;    green <= x_q;    blue <= d_none;
        end
        SEC_1: begin
          red <= x_q;    green <= d_v;    blue <= d_none;
        end
        SEC_2: begin
          red <= d_none; green <= d_v;    blue <= x_q;
        end
        SEC_3: begin
          red <= d_none; green <= x_q;    blue <= d_v;
        end
        SEC_4: begin
          red <= x_q;    green <= d_none; blue <= d_v;
        end
        default: begin
          red <= d_v;    green <= d_none; blue <= x_q;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Reciprocal estimates are never more than one short
  a_x_rem_bound: assert property (@(posedge clk) disable iff (rst)
    d_vld |-> (x_rem < NUM_W'(DIV_X) * NUM_W'(2)))
    else $error("secondary quotient estimate off by more than one");

  a_n_rem_bound: assert property (@(posedge clk) disable iff (rst)
    c_vld |-> (n_rem < PROD_W'(DIV_N) * PROD_W'(2)))
    else $error("offset quotient estimate off by more than one");

  // A blocked stage D keeps its item
  a_d_hold: assert property (@(posedge clk) disable iff (rst)
    (d_vld && !e_rdy) |=> (d_vld && $stable(d_num) && $stable(d_none)))
    else $error("stage D item changed while blocked");
`endif

endmodule
